// ----- hw/rtl/utxf_pkg.sv -----
// utxf_pkg: shared types, constants and helper functions of the uart transmitter
// with character fifo; used by the interfaces and the top level
// no dependencies

package utxf_pkg;

    // character and register widths
    localparam int CHAR_W      = 9;
    localparam int BITS_W      = 4;
    localparam int TICKS_W     = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_ADDR_W  = 1;
    localparam int PHASE_W     = 4;
    localparam int SLOT_W      = 4;

    // default character fifo depth
    localparam int FIFO_DEPTH_DEF = 64;

    // register reset values
    localparam logic [BITS_W-1:0]  DATA_BITS_RST = 4'd8;
    localparam logic [TICKS_W-1:0] TICKS_RST     = 5'd5;

    // effective ranges
    localparam logic [BITS_W-1:0]  DATA_BITS_MIN = 4'd5;
    localparam logic [BITS_W-1:0]  DATA_BITS_MAX = 4'd9;
    localparam logic [TICKS_W-1:0] TICKS_MIN     = 5'd1;
    localparam logic [TICKS_W-1:0] TICKS_MAX     = 5'd16;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_DATA_BITS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TICKS     = 1'b1;

    // item commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    // bit slot codes
    localparam logic [SLOT_W-1:0] SLOT_START = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_FIRST = 4'd1;

    function automatic logic [BITS_W-1:0] eff_data_bits(input logic [BITS_W-1:0] v);
        logic [BITS_W-1:0] r;
        r = v;
        if (v < DATA_BITS_MIN)
        begin
            r = DATA_BITS_MIN;
        end
        else if (v > DATA_BITS_MAX)
        begin
            r = DATA_BITS_MAX;
        end
        return r;
    endfunction

    function automatic logic [TICKS_W-1:0] eff_ticks(input logic [TICKS_W-1:0] v);
        logic [TICKS_W-1:0] r;
        r = v;
        if (v < TICKS_MIN)
        begin
            r = TICKS_MIN;
        end
        else if (v > TICKS_MAX)
        begin
            r = TICKS_MAX;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/utxf_if.sv -----
// utxf_if: valid/ready channel interfaces of the uart transmitter,
// one for the input items and one for the result beats
// depends on utxf_pkg

interface utxf_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [utxf_pkg::CHAR_W-1:0]  data_byte;
    logic                         commit;

    modport source (output valid, cmd, data_byte, commit, input ready);
    modport sink   (input valid, cmd, data_byte, commit, output ready);
endinterface

interface utxf_out_if;
    logic valid;
    logic ready;
    logic tx_line;
    logic busy_res;
    logic refused;
    logic dropped;

    modport source (output valid, tx_line, busy_res, refused, dropped, input ready);
    modport sink   (input valid, tx_line, busy_res, refused, dropped, output ready);
endinterface

// ----- hw/rtl/utxf_ram.sv -----
// utxf_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module utxf_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/uart_tx_with_fifo.sv -----
// uart_tx_with_fifo: serial transmitter with a character fifo, top level
// depends on utxf_pkg, utxf_if (utxf_in_if, utxf_out_if) and utxf_ram
//
// usage
//   in_ch carries one item per beat: cmd selects a tick of time or a push of
//   data_byte into the fifo; commit on a push starts transmission. pushes are
//   refused while the transmitter is busy and dropped when the fifo is full
//   out_ch gives exactly one result beat per item: the line level, busy, and
//   the refused / dropped flags of that item
//   each slot of ticks_per_bit ticks sends one bit: start (low), data bits
//   lsb first, stop (high), one idle gap; then the next queued character
//   result: the beat is registered and valid in the cycle after acceptance
//   throughput: one item per cycle when out_ch is not stalled; every item
//   is one state update; the head is prefetched via the ram's registered port
//   stall: when out_ch is stalled the result waits in the output register and
//   in_ch.ready drops until it is taken; no beat is lost or repeated
//   reset: line idles high, fifo empty, not busy, data_bits 8, ticks_per_bit 5
//   config writes (cfg_we, cfg_addr, cfg_data) take effect on the next item

module uart_tx_with_fifo #(
    parameter int FIFO_DEPTH = utxf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    utxf_in_if.sink                             in_ch,
    utxf_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [utxf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [utxf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // configuration registers
    logic [utxf_pkg::BITS_W-1:0]  data_bits_reg;
    logic [utxf_pkg::TICKS_W-1:0] ticks_reg;

    // transmitter state
    logic [utxf_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [utxf_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [utxf_pkg::CHAR_W-1:0]  shift_reg, shift_next;
    logic                         sending_reg, sending_next;
    logic                         busy_reg, busy_next;
    logic                         line_reg, line_next;

    // fifo pointers
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // head prefetch and write bypass
    logic [utxf_pkg::CHAR_W-1:0] ram_rdata;
    logic [utxf_pkg::CHAR_W-1:0] byp_data_reg;
    logic                        byp_reg;
    logic [utxf_pkg::CHAR_W-1:0] head_data;
    logic                        ram_we;
    logic                        pop;

    // output register
    logic out_valid_reg;
    logic tx_line_reg, busy_res_reg, refused_reg, dropped_reg;
    logic refused_next, dropped_next;

    logic                         accept;
    logic [utxf_pkg::BITS_W-1:0]  nb;
    logic [utxf_pkg::SLOT_W:0]    stop_slot;
    logic [utxf_pkg::TICKS_W-1:0] nticks;
    logic [utxf_pkg::TICKS_W-1:0] phase_inc;

    // a new item enters whenever the output register is free or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign nb        = utxf_pkg::eff_data_bits(data_bits_reg);
    assign nticks    = utxf_pkg::eff_ticks(ticks_reg);
    assign stop_slot = {1'b0, nb} + 5'd1;
    assign phase_inc = {1'b0, phase_reg} + 5'd1;

    // the character at the head: freshly written entry wins over the ram read
    assign head_data = byp_reg ? byp_data_reg : ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bits_reg <= utxf_pkg::DATA_BITS_RST;
            ticks_reg     <= utxf_pkg::TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                utxf_pkg::REG_DATA_BITS: data_bits_reg <= cfg_data[utxf_pkg::BITS_W-1:0];
                utxf_pkg::REG_TICKS:     ticks_reg     <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // next state for one accepted item
    always_comb
    begin
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        shift_next   = shift_reg;
        sending_next = sending_reg;
        busy_next    = busy_reg;
        line_next    = line_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        refused_next = 1'b0;
        dropped_next = 1'b0;
        ram_we       = 1'b0;
        pop          = 1'b0;

        if (accept)
        begin
            case (in_ch.cmd)
                utxf_pkg::CMD_PUSH:
                begin
                    if (busy_reg)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        if (in_ch.commit)
                        begin
                            busy_next    = 1'b1;
                            sending_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // one bit slot runs on phase zero
                    if (phase_reg == '0 && sending_reg)
                    begin
                        if (slot_reg == utxf_pkg::SLOT_START)
                        begin
                            busy_next = 1'b1;
                            line_next = 1'b0;
                            slot_next = utxf_pkg::SLOT_FIRST;
                            if (count_reg != '0)
                            begin
                                pop        = 1'b1;
                                shift_next = head_data;
                                head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                shift_next = '0;
                            end
                        end
                        else if ({1'b0, slot_reg} < stop_slot)
                        begin
                            line_next  = shift_reg[0];
                            shift_next = shift_reg >> 1;
                            slot_next  = slot_reg + 1'b1;
                        end
                        else if ({1'b0, slot_reg} == stop_slot)
                        begin
                            line_next = 1'b1;
                            slot_next = slot_reg + 1'b1;
                        end
                        else
                        begin
                            // gap slot, also any slot past the stop bit
                            slot_next = utxf_pkg::SLOT_START;
                            if (count_reg == '0)
                            begin
                                busy_next    = 1'b0;
                                sending_next = 1'b0;
                            end
                        end
                    end
                    phase_next = (phase_inc >= nticks) ? '0
                                                       : phase_inc[utxf_pkg::PHASE_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            slot_reg    <= utxf_pkg::SLOT_START;
            shift_reg   <= '0;
            sending_reg <= 1'b0;
            busy_reg    <= 1'b0;
            line_reg    <= 1'b1;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            slot_reg    <= slot_next;
            shift_reg   <= shift_next;
            sending_reg <= sending_next;
            busy_reg    <= busy_next;
            line_reg    <= line_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            // the ram read of head_next misses a write to the same entry
            byp_reg     <= ram_we && (tail_reg == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= in_ch.data_byte;
    end

    // character store, read address is head_next, the next head pointer value
    utxf_ram #(
        .WIDTH (utxf_pkg::CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (in_ch.data_byte),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_line_reg  <= line_next;
            busy_res_reg <= busy_next;
            refused_reg  <= refused_next;
            dropped_reg  <= dropped_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.tx_line  = tx_line_reg;
    assign out_ch.busy_res = busy_res_reg;
    assign out_ch.refused  = refused_reg;
    assign out_ch.dropped  = dropped_reg;

    // fill level never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("fifo count beyond depth");

    // empty or full fifo has its pointers together
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_FULL) |-> head_reg == tail_reg)
        else $error("fifo pointers out of step with count");

    // a push is never queued in the cycle of a pop
    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && pop))
        else $error("push and pop in the same cycle");

    // an idle transmitter sits on the start slot
    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> slot_reg == utxf_pkg::SLOT_START)
        else $error("bit slot moved while not sending");

    // a refused push is only reported while busy
    a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && refused_reg) |-> busy_res_reg)
        else $error("refused without busy");

endmodule
